>>> rtl/dtpg_pkg.sv
// ----------------------------------------------------------------------------
// dtpg_pkg
// Shared constants, types and lookup functions for the test pattern generator.
// ----------------------------------------------------------------------------
package dtpg_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    localparam int XW = $clog2(FRAME_WIDTH);
    localparam int YW = $clog2(FRAME_HEIGHT);
    // width of row * FRAME_WIDTH
    localparam int PW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

    // reciprocal constants for division by constants
    localparam int DIV_SH = 32;
    localparam longint unsigned RCP_H =
        ((64'd1 << DIV_SH) + FRAME_HEIGHT - 1) / FRAME_HEIGHT;
    localparam int RHW = $clog2(RCP_H + 1);
    localparam int BAR_W = FRAME_WIDTH / 8;
    localparam longint unsigned RCP_BAR =
        ((64'd1 << DIV_SH) + BAR_W - 1) / BAR_W;
    localparam int RBW = $clog2(RCP_BAR + 1);

    localparam int CAP_SH = 16;
    localparam int RCP_P12 = ((1 << CAP_SH) + 11) / 12;
    localparam int RCP_P18 = ((1 << CAP_SH) + 17) / 18;
    localparam int RCP_S3  = ((1 << CAP_SH) + 2) / 3;

    typedef enum logic [1:0] {
        MODE_BARS    = 2'd0,
        MODE_GRID    = 2'd1,
        MODE_CHECKER = 2'd2,
        MODE_CARD    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          eol;
        logic          eof;
        logic [PW-1:0] yw;
    } pos_t;

    function automatic logic [15:0] mk565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    localparam logic [15:0] C_BLACK   = mk565(8'd0, 8'd0, 8'd0);
    localparam logic [15:0] C_WHITE   = mk565(8'd255, 8'd255, 8'd255);
    localparam logic [15:0] C_RED     = mk565(8'd220, 8'd40, 8'd40);
    localparam logic [15:0] C_GREEN   = mk565(8'd40, 8'd200, 8'd80);
    localparam logic [15:0] C_BLUE    = mk565(8'd60, 8'd110, 8'd240);
    localparam logic [15:0] C_YELLOW  = mk565(8'd240, 8'd210, 8'd40);
    localparam logic [15:0] C_CYAN    = mk565(8'd40, 8'd200, 8'd220);
    localparam logic [15:0] C_MAGENTA = mk565(8'd220, 8'd60, 8'd200);
    localparam logic [15:0] C_GRAY    = mk565(8'd90, 8'd90, 8'd90);
    localparam logic [15:0] C_DARK    = mk565(8'd24, 8'd28, 8'd34);

    function automatic logic [15:0] bar_color(input logic [3:0] k);
        logic [15:0] c;
        case (k)
            4'd0:    c = C_WHITE;
            4'd1:    c = C_YELLOW;
            4'd2:    c = C_CYAN;
            4'd3:    c = C_GREEN;
            4'd4:    c = C_MAGENTA;
            4'd5:    c = C_RED;
            4'd6:    c = C_BLUE;
            default: c = C_BLACK;
        endcase
        return c;
    endfunction

    // 5x7 font, top row in the high bits; unknown codes are solid
    function automatic logic [4:0] font_row(input logic [7:0] ch, input logic [2:0] r);
        logic [34:0] g;
        logic [2:0]  rr;
        rr = (r == 3'd7) ? 3'd0 : r;
        case (ch)
            " ":     g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            "0":     g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1":     g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2":     g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3":     g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            "4":     g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "6":     g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "C":     g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D":     g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            "E":     g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "G":     g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H":     g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I":     g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "K":     g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "P":     g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "R":     g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S":     g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T":     g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "X":     g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            default: g = {35{1'b1}};
        endcase
        return g[(3'd6 - rr) * 5 +: 5];
    endfunction

    localparam logic [8*9-1:0]  CAP_GRID    = "GRID 16PX";
    localparam logic [8*12-1:0] CAP_CHECKER = "CHECKER 16PX";
    localparam logic [8*12-1:0] CAP_CARD    = "320X240 TEST";

    // character idx of the caption for a mode; blank past the end
    function automatic logic [7:0] cap_char(input mode_t mode, input logic [3:0] idx);
        logic [7:0] ch;
        ch = " ";
        case (mode)
            MODE_GRID:    if (idx < 4'd9)  ch = CAP_GRID[8 * (4'd8 - idx) +: 8];
            MODE_CHECKER: if (idx < 4'd12) ch = CAP_CHECKER[8 * (4'd11 - idx) +: 8];
            MODE_CARD:    if (idx < 4'd12) ch = CAP_CARD[8 * (4'd11 - idx) +: 8];
            default:      ch = " ";
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/dtpg_front.sv
// ----------------------------------------------------------------------------
// dtpg_front
// Raster position counters: take requests, tag each with its position.
// ----------------------------------------------------------------------------
module dtpg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             restart_frame,
    input  logic             q_full,
    output logic             q_push,
    output dtpg_pkg::pos_t   q_data
);

    logic [dtpg_pkg::XW-1:0] col_reg, col_next;
    logic [dtpg_pkg::YW-1:0] row_reg, row_next;
    logic [dtpg_pkg::XW-1:0] x_cur;
    logic [dtpg_pkg::YW-1:0] y_cur;
    logic                    eol, eof;

    // pick the position of this pixel and its line/frame flags
    always_comb
    begin
        x_cur  = restart_frame ? '0 : col_reg;
        y_cur  = restart_frame ? '0 : row_reg;
        eol    = (x_cur == dtpg_pkg::XW'(dtpg_pkg::FRAME_WIDTH - 1));
        eof    = eol && (y_cur == dtpg_pkg::YW'(dtpg_pkg::FRAME_HEIGHT - 1));
        q_push = push && !q_full;
        q_data.x   = x_cur;
        q_data.y   = y_cur;
        q_data.eol = eol;
        q_data.eof = eof;
        q_data.yw  = dtpg_pkg::PW'(y_cur * dtpg_pkg::FRAME_WIDTH);
    end

    // advance the raster on each transfer
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (eol)
            begin
                col_next = '0;
                row_next = eof ? '0 : y_cur + 1'b1;
            end
            else
            begin
                col_next = x_cur + 1'b1;
                row_next = y_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/dtpg_queue.sv
// ----------------------------------------------------------------------------
// dtpg_queue
// Two-entry queue of tagged positions between front and back.
// ----------------------------------------------------------------------------
module dtpg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dtpg_pkg::pos_t din,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output dtpg_pkg::pos_t dout
);

    dtpg_pkg::pos_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // hold entries; no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> rtl/dtpg_back.sv
// ----------------------------------------------------------------------------
// dtpg_back
// Two-stage colour pipeline: divide and classify, then paint and register.
// ----------------------------------------------------------------------------
module dtpg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dtpg_pkg::mode_t mode,
    input  logic            q_valid,
    input  dtpg_pkg::pos_t  q_data,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [15:0]     pixel_color,
    output logic [8:0]      pixel_x,
    output logic [7:0]      pixel_y,
    output logic            end_of_line,
    output logic            end_of_frame
);

    localparam int XW = dtpg_pkg::XW;
    localparam int YW = dtpg_pkg::YW;
    localparam int W  = dtpg_pkg::FRAME_WIDTH;
    localparam int H  = dtpg_pkg::FRAME_HEIGHT;
    localparam int EW = XW + 2;

    localparam int GRID_Y0 = H - 20;
    localparam int CARD_Y0 = H / 2 - 8;

    // caption placement per mode
    logic [XW-1:0] cap_x0;
    logic [YW-1:0] cap_y0;
    logic          cap_s3;
    logic [3:0]    cap_len;
    logic          cap_on;
    logic [15:0]   cap_fg, cap_bg;

    always_comb
    begin
        cap_x0  = XW'(8);
        cap_y0  = YW'(GRID_Y0);
        cap_s3  = 1'b0;
        cap_len = 4'd9;
        cap_on  = 1'b1;
        cap_fg  = dtpg_pkg::C_WHITE;
        cap_bg  = dtpg_pkg::C_DARK;
        case (mode)
            dtpg_pkg::MODE_GRID:
            begin
                cap_y0 = YW'(GRID_Y0);
            end
            dtpg_pkg::MODE_CHECKER:
            begin
                cap_y0  = YW'(8);
                cap_len = 4'd12;
                cap_fg  = dtpg_pkg::C_RED;
                cap_bg  = dtpg_pkg::C_WHITE;
            end
            dtpg_pkg::MODE_CARD:
            begin
                cap_x0  = XW'(28);
                cap_y0  = YW'(CARD_Y0);
                cap_s3  = 1'b1;
                cap_len = 4'd12;
            end
            default:
            begin
                cap_on = 1'b0;
            end
        endcase
    end

    // handshake along the pipeline
    logic a_valid_reg, b_valid_reg;
    logic ready_a, ready_b;

    assign ready_b = !b_valid_reg || pop;
    assign ready_a = !a_valid_reg || ready_b;
    assign q_pop   = q_valid && ready_a;
    assign empty   = !b_valid_reg;

    // stage A: constant divisions by reciprocal multiply
    logic [dtpg_pkg::PW+dtpg_pkg::RHW-1:0] xa_prod;
    logic [XW+dtpg_pkg::RBW-1:0]           bar_prod;
    logic [XW+dtpg_pkg::CAP_SH-1:0]        idx_prod;
    logic [5+dtpg_pkg::CAP_SH-1:0]         row_prod;
    logic [dtpg_pkg::CAP_SH-1:0]           rcp_p;
    logic [XW-1:0]                         dx;
    logic [4:0]                            dy;
    logic                                  inwin;
    logic [YW:0]                           y_end;

    always_comb
    begin
        xa_prod  = q_data.yw * dtpg_pkg::RCP_H[dtpg_pkg::RHW-1:0];
        bar_prod = q_data.x * dtpg_pkg::RCP_BAR[dtpg_pkg::RBW-1:0];
        rcp_p    = cap_s3 ? dtpg_pkg::CAP_SH'(dtpg_pkg::RCP_P18)
                          : dtpg_pkg::CAP_SH'(dtpg_pkg::RCP_P12);
        dx       = q_data.x - cap_x0;
        dy       = 5'(q_data.y - cap_y0);
        idx_prod = dx * rcp_p;
        row_prod = dy * dtpg_pkg::CAP_SH'(dtpg_pkg::RCP_S3);
        y_end    = {1'b0, cap_y0} + (cap_s3 ? (YW+1)'(21) : (YW+1)'(14));
        inwin    = cap_on && (q_data.x >= cap_x0) && (q_data.y >= cap_y0)
                   && ({1'b0, q_data.y} < y_end);
    end

    logic [XW-1:0] a_x_reg;
    logic [YW-1:0] a_y_reg;
    logic          a_eol_reg, a_eof_reg;
    logic [XW-1:0] a_xa_reg;
    logic [3:0]    a_bar_reg;
    logic          a_inwin_reg;
    logic [XW-1:0] a_dx_reg;
    logic [XW-1:0] a_idx_reg;
    logic [2:0]    a_row_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_x_reg     <= q_data.x;
            a_y_reg     <= q_data.y;
            a_eol_reg   <= q_data.eol;
            a_eof_reg   <= q_data.eof;
            a_xa_reg    <= xa_prod[dtpg_pkg::DIV_SH +: XW];
            a_bar_reg   <= bar_prod[dtpg_pkg::DIV_SH +: 4];
            a_inwin_reg <= inwin;
            a_dx_reg    <= dx;
            a_idx_reg   <= idx_prod[dtpg_pkg::CAP_SH +: XW];
            a_row_reg   <= cap_s3 ? row_prod[dtpg_pkg::CAP_SH +: 3] : dy[3:1];
        end
    end

    // stage B: caption cell, base pattern, layering
    logic [4:0]    pitch;
    logic [XW-1:0] rem;
    logic [20:0]   col_prod;
    logic [2:0]    gcol;
    logic [EW-1:0] cap_right;
    logic          paint;
    logic [4:0]    frow;
    logic          fbit;
    logic [15:0]   base;
    logic [15:0]   color;
    logic [XW:0]   xa1;
    logic [EW-1:0] anti;

    always_comb
    begin
        pitch     = cap_s3 ? 5'd18 : 5'd12;
        rem       = a_dx_reg - XW'(a_idx_reg * pitch);
        col_prod  = rem[4:0] * dtpg_pkg::CAP_SH'(dtpg_pkg::RCP_S3);
        gcol      = cap_s3 ? col_prod[dtpg_pkg::CAP_SH +: 3] : rem[3:1];
        cap_right = EW'(cap_x0) + EW'(EW'(pitch) * (EW'(a_idx_reg) + 1'b1));
        paint     = a_inwin_reg
                    && (rem < (cap_s3 ? XW'(15) : XW'(10)))
                    && (a_idx_reg < XW'(cap_len))
                    && !((a_idx_reg != '0) && (cap_right > EW'(W)));
        frow      = dtpg_pkg::font_row(dtpg_pkg::cap_char(mode, a_idx_reg[3:0]), a_row_reg);
        fbit      = frow[3'd4 - gcol];

        xa1  = {1'b0, a_xa_reg} + 1'b1;
        anti = EW'(a_x_reg) + EW'(a_xa_reg);

        base = dtpg_pkg::C_DARK;
        case (mode)
            dtpg_pkg::MODE_BARS:
            begin
                base = dtpg_pkg::bar_color((a_bar_reg > 4'd7) ? 4'd7 : a_bar_reg);
            end
            dtpg_pkg::MODE_GRID:
            begin
                if ((a_x_reg[3:0] == 4'd0) || (a_y_reg[3:0] == 4'd0))
                begin
                    base = dtpg_pkg::C_GRAY;
                end
            end
            dtpg_pkg::MODE_CHECKER:
            begin
                base = (a_x_reg[4] ^ a_y_reg[4]) ? dtpg_pkg::C_WHITE : dtpg_pkg::C_BLACK;
            end
            default:
            begin
                if ((a_y_reg < YW'(2)) || (a_y_reg >= YW'(H - 2))
                    || (a_x_reg < XW'(2)) || (a_x_reg >= XW'(W - 2)))
                begin
                    base = dtpg_pkg::C_WHITE;
                end
                if ((a_x_reg == a_xa_reg) || ({1'b0, a_x_reg} == xa1))
                begin
                    base = dtpg_pkg::C_YELLOW;
                end
                if ((anti + 1'b1 == EW'(W)) || (anti == EW'(W)))
                begin
                    base = dtpg_pkg::C_CYAN;
                end
                if ((a_y_reg >= YW'(2)) && (a_y_reg < YW'(14)))
                begin
                    if ((a_x_reg >= XW'(2)) && (a_x_reg < XW'(14)))
                        base = dtpg_pkg::C_RED;
                    if ((a_x_reg >= XW'(W - 14)) && (a_x_reg < XW'(W - 2)))
                        base = dtpg_pkg::C_GREEN;
                end
                if ((a_y_reg >= YW'(H - 14)) && (a_y_reg < YW'(H - 2)))
                begin
                    if ((a_x_reg >= XW'(2)) && (a_x_reg < XW'(14)))
                        base = dtpg_pkg::C_BLUE;
                    if ((a_x_reg >= XW'(W - 14)) && (a_x_reg < XW'(W - 2)))
                        base = dtpg_pkg::C_MAGENTA;
                end
            end
        endcase

        color = paint ? (fbit ? cap_fg : cap_bg) : base;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ready_b && a_valid_reg)
        begin
            pixel_color  <= color;
            pixel_x      <= 9'(a_x_reg);
            pixel_y      <= 8'(a_y_reg);
            end_of_line  <= a_eol_reg;
            end_of_frame <= a_eof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                a_valid_reg <= q_valid;
            if (ready_b)
                b_valid_reg <= a_valid_reg;
        end
    end

endmodule

>>> rtl/display_test_pattern_generator_unit.sv
// ----------------------------------------------------------------------------
// display_test_pattern_generator_unit
// Raster-order RGB565 test pattern source with selectable pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the request side (push while full is low) asks for the
//   next pixel in raster order; restart_frame set with it restarts at (0,0).
//   Each request yields exactly one pixel on the result side, shown while
//   empty is low and taken with pop, with its position and end of line and
//   end of frame flags. The pattern register is written through
//   cfg_valid/cfg_ready/cfg_data (cfg_ready is always high); the user must
//   write it only while no requests are in flight; the block does not check.
// Pipeline and throughput:
//   A pixel passes from its request transfer through the position queue and
//   the divide stage, whose result the paint logic loads into the output
//   register. One pixel per clock is sustained while pop stays high; the
//   two-entry queue and the elastic pipeline keep requests flowing.
// Reset and stall:
//   Reset clears the raster position, selects colour bars and empties the
//   pipeline. When pop stays low the pipeline fills and full rises; no
//   pixel is dropped or repeated.
// ----------------------------------------------------------------------------
module display_test_pattern_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        restart_frame,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] pixel_color,
    output logic [8:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic        end_of_line,
    output logic        end_of_frame
);

    dtpg_pkg::mode_t mode_reg;
    dtpg_pkg::pos_t  fq_data, qb_data;
    logic            fq_push, qb_valid, qb_pop;

    assign cfg_ready = 1'b1;

    // hold the pattern selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= dtpg_pkg::MODE_BARS;
        else if (cfg_valid && cfg_ready)
            mode_reg <= dtpg_pkg::mode_t'(cfg_data);
    end

    dtpg_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .restart_frame (restart_frame),
        .q_full        (full),
        .q_push        (fq_push),
        .q_data        (fq_data)
    );

    dtpg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_data),
        .full  (full),
        .pop   (qb_pop),
        .valid (qb_valid),
        .dout  (qb_data)
    );

    dtpg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .q_valid      (qb_valid),
        .q_data       (qb_data),
        .q_pop        (qb_pop),
        .pop          (pop),
        .empty        (empty),
        .pixel_color  (pixel_color),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

endmodule

>>> rtl/dtpg_checker.sv
// ----------------------------------------------------------------------------
// dtpg_checker
// Port-level checks of the pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
module dtpg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] pixel_color,
    input logic [8:0]  pixel_x,
    input logic [7:0]  pixel_y,
    input logic        end_of_line,
    input logic        end_of_frame
);

    // nothing to show while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // line flag marks exactly the last column
    a_eol: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (end_of_line == (pixel_x == 9'(dtpg_pkg::FRAME_WIDTH - 1))))
        else $error("end_of_line disagrees with pixel_x");

    // frame flag only on the last pixel of the last row
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_frame) |->
            (end_of_line && (pixel_y == 8'(dtpg_pkg::FRAME_HEIGHT - 1))))
        else $error("end_of_frame off the last pixel");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_color) && $stable(pixel_x)
                              && $stable(pixel_y)))
        else $error("stalled result changed");

endmodule

bind display_test_pattern_generator_unit dtpg_checker u_dtpg_checker (.*);

>>> bench/display_test_pattern_generator_unit_checker.sv
// ----------------------------------------------------------------------------
// display_test_pattern_generator_unit_checker
// Watches the request, pixel and pattern-select channels, predicts every
// pixel from its own raster position and pattern model, and counts mismatches.
// ----------------------------------------------------------------------------
module display_test_pattern_generator_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        restart_frame,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] pixel_color,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic        end_of_line,
    input  logic        end_of_frame,
    output int          fail_count,
    output int          pixels_seen,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = dtpg_pkg::FRAME_WIDTH;
    localparam int H = dtpg_pkg::FRAME_HEIGHT;

    typedef struct {
        logic [15:0] color;
        logic [8:0]  x;
        logic [7:0]  y;
        logic        eol;
        logic        eof;
    } pixel_t;

    pixel_t          expected_pixels[$];
    int              scan_col;
    int              scan_row;
    dtpg_pkg::mode_t cur_mode;

    assign pending = expected_pixels.size();

    function automatic logic [4:0] glyph_bits(input byte ch, input int r);
        logic [4:0] g[7];
        case (ch)
            " ": g = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            "0": g = '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1": g = '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2": g = '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3": g = '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
            "4": g = '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
            "6": g = '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "C": g = '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": g = '{5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
            "E": g = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "G": g = '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H": g = '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": g = '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "K": g = '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "P": g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "R": g = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": g = '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": g = '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "X": g = '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            default: g = '{5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F};
        endcase
        return g[r % 7];
    endfunction

    // paint a caption cell over c; the gap column keeps c
    function automatic void paint_caption(input int x, input int y, input int x0,
                                          input int y0, input string txt, input int s,
                                          input logic [15:0] fg, input logic [15:0] bg,
                                          inout logic [15:0] c);
        int pitch, dx, i, rem;
        logic [4:0] bits;
        pitch = 6 * s;
        if (x < x0 || y < y0 || y >= y0 + 7 * s) return;
        dx  = x - x0;
        i   = dx / pitch;
        rem = dx % pitch;
        if (rem >= 5 * s || i >= txt.len()) return;
        // drop later characters that run past the right edge
        if (i > 0 && x0 + pitch * (i + 1) > W) return;
        bits = glyph_bits(txt[i], (y - y0) / s);
        c = bits[4 - rem / s] ? fg : bg;
    endfunction

    function automatic logic [15:0] pattern_color(input dtpg_pkg::mode_t m, input int x,
                                                  input int y);
        logic [15:0] c;
        int k, xa;
        logic [15:0] bars[8];
        bars = '{dtpg_pkg::C_WHITE, dtpg_pkg::C_YELLOW, dtpg_pkg::C_CYAN,
                 dtpg_pkg::C_GREEN, dtpg_pkg::C_MAGENTA, dtpg_pkg::C_RED,
                 dtpg_pkg::C_BLUE, dtpg_pkg::C_BLACK};
        c = dtpg_pkg::C_DARK;
        case (m)
            dtpg_pkg::MODE_BARS:
            begin
                k = x / (W / 8);
                c = bars[k > 7 ? 7 : k];
            end
            dtpg_pkg::MODE_GRID:
            begin
                if (x % 16 == 0 || y % 16 == 0) c = dtpg_pkg::C_GRAY;
                paint_caption(x, y, 8, H - 20, "GRID 16PX", 2,
                              dtpg_pkg::C_WHITE, dtpg_pkg::C_DARK, c);
            end
            dtpg_pkg::MODE_CHECKER:
            begin
                c = ((x / 16 + y / 16) & 1) ? dtpg_pkg::C_WHITE : dtpg_pkg::C_BLACK;
                paint_caption(x, y, 8, 8, "CHECKER 16PX", 2,
                              dtpg_pkg::C_RED, dtpg_pkg::C_WHITE, c);
            end
            default:
            begin
                xa = (y * W) / H;
                if (y < 2 || y >= H - 2 || x < 2 || x >= W - 2)
                    c = dtpg_pkg::C_WHITE;
                if (x == xa || x == xa + 1) c = dtpg_pkg::C_YELLOW;
                if (x + 1 + xa == W || x + xa == W) c = dtpg_pkg::C_CYAN;
                if (y >= 2 && y < 14)
                begin
                    if (x >= 2 && x < 14) c = dtpg_pkg::C_RED;
                    if (x >= W - 14 && x < W - 2) c = dtpg_pkg::C_GREEN;
                end
                if (y >= H - 14 && y < H - 2)
                begin
                    if (x >= 2 && x < 14) c = dtpg_pkg::C_BLUE;
                    if (x >= W - 14 && x < W - 2) c = dtpg_pkg::C_MAGENTA;
                end
                paint_caption(x, y, 28, H / 2 - 8, "320X240 TEST", 3,
                              dtpg_pkg::C_WHITE, dtpg_pkg::C_DARK, c);
            end
        endcase
        return c;
    endfunction

    // predict on request transfers, compare on pixel transfers
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            expected_pixels.delete();
            scan_col   = 0;
            scan_row   = 0;
            cur_mode   = dtpg_pkg::MODE_BARS;
            fail_count = 0;
            pixels_seen = 0;
        end
        else
        begin
            if (!empty && pop)
            begin
                pixels_seen++;
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel transfer with no request waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (pixel_color !== e.color)
                    begin
                        $error("pixel_color expected %h actual %h", e.color, pixel_color);
                        fail_count++;
                    end
                    if (pixel_x !== e.x)
                    begin
                        $error("pixel_x expected %0d actual %0d", e.x, pixel_x);
                        fail_count++;
                    end
                    if (pixel_y !== e.y)
                    begin
                        $error("pixel_y expected %0d actual %0d", e.y, pixel_y);
                        fail_count++;
                    end
                    if (end_of_line !== e.eol)
                    begin
                        $error("end_of_line expected %b actual %b", e.eol, end_of_line);
                        fail_count++;
                    end
                    if (end_of_frame !== e.eof)
                    begin
                        $error("end_of_frame expected %b actual %b", e.eof, end_of_frame);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                if (restart_frame)
                begin
                    scan_col = 0;
                    scan_row = 0;
                end
                e.color = pattern_color(cur_mode, scan_col, scan_row);
                e.x     = scan_col[8:0];
                e.y     = scan_row[7:0];
                e.eol   = (scan_col == W - 1);
                e.eof   = e.eol && (scan_row == H - 1);
                expected_pixels.push_back(e);
                scan_col++;
                if (scan_col >= W)
                begin
                    scan_col = 0;
                    scan_row++;
                    if (scan_row >= H) scan_row = 0;
                end
            end
            if (cfg_valid && cfg_ready)
                cur_mode = dtpg_pkg::mode_t'(cfg_data);
        end
    end

endmodule

>>> bench/display_test_pattern_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// display_test_pattern_generator_unit_tb
// Drives pixel requests under each pattern with varied restart use, idling
// and back-pressure; a checker module predicts and compares every pixel.
// ----------------------------------------------------------------------------
module display_test_pattern_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_OFF_LEN = 60;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        restart_frame;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;
    logic        empty;
    logic        pop;
    logic [15:0] pixel_color;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        end_of_line;
    logic        end_of_frame;
    int          fail_count;
    int          pixels_seen;
    int          pending;
    int          cycle_count;
    int          send_idle_pct;
    int          pop_stall_pct;
    int          hold_off_req;
    int          hold_off_done;
    int          hold_off_cycles;
    int          requests_sent;

    display_test_pattern_generator_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .restart_frame(restart_frame), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .empty(empty), .pop(pop), .pixel_color(pixel_color),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .end_of_line(end_of_line),
        .end_of_frame(end_of_frame)
    );

    display_test_pattern_generator_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .restart_frame(restart_frame), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .empty(empty), .pop(pop), .pixel_color(pixel_color),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .end_of_line(end_of_line),
        .end_of_frame(end_of_frame), .fail_count(fail_count),
        .pixels_seen(pixels_seen), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // count cycles and stop a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("display_test_pattern_generator_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // drive pop at the falling edge; honor stall rate and hold-off
    initial
    begin
        pop = 1'b0;
        hold_off_done = 0;
        hold_off_cycles = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req != hold_off_done)
            begin
                hold_off_done = hold_off_req;
                hold_off_cycles = HOLD_OFF_LEN;
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // send one request and wait for its transfer
    task automatic send_request(input logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push          <= 1'b0;
            restart_frame <= 1'($urandom_range(1));
            @(negedge clk);
        end
        push          <= 1'b1;
        restart_frame <= restart;
        @(posedge clk);
        while (full) @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    // wait for the pipe to drain, then select a new pattern
    task automatic set_pattern(input dtpg_pkg::mode_t m);
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (5) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= 2'($urandom_range(3));
    endtask

    initial
    begin
        int idle_sets[4][2];
        dtpg_pkg::mode_t order[6];
        idle_sets = '{'{0, 0}, '{54, 0}, '{0, 54}, '{13, 13}};
        order     = '{dtpg_pkg::MODE_BARS, dtpg_pkg::MODE_GRID, dtpg_pkg::MODE_CHECKER,
                      dtpg_pkg::MODE_CARD, dtpg_pkg::MODE_GRID, dtpg_pkg::MODE_BARS};
        rst_n = 1'b0;
        push = 1'b0;
        restart_frame = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 2'd0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_off_req = 0;
        requests_sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: frame start, restart, every pattern briefly
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        for (int m = 0; m < 4; m++)
        begin
            set_pattern(dtpg_pkg::mode_t'(m));
            for (int i = 0; i < 4; i++) send_request(i == 0);
        end

        // random: each pattern under each idling mix, mostly streaming
        for (int p = 0; p < 6; p++)
        begin
            set_pattern(order[p]);
            for (int ph = 0; ph < 4; ph++)
            begin
                send_idle_pct = idle_sets[ph][0];
                pop_stall_pct = idle_sets[ph][1];
                if (p == 0 && ph == 0) hold_off_req++;
                for (int i = 0; i < 80; i++)
                    send_request($urandom_range(63) == 0);
            end
        end

        // a short test card run from the frame start
        set_pattern(dtpg_pkg::MODE_CARD);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_request(1'b1);
        repeat (10) send_request(1'b0);

        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Ran %0d pixel requests, %0d pixels checked over all four patterns,",
                 requests_sent, pixels_seen);
        $display("with restarts, idling mixes and a long output hold-off.");
        if (fail_count == 0)
            $display("display_test_pattern_generator_unit_tb OK");
        else
            $display("display_test_pattern_generator_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> display_test_pattern_generator_unit.f
rtl/dtpg_pkg.sv
rtl/dtpg_front.sv
rtl/dtpg_queue.sv
rtl/dtpg_back.sv
rtl/display_test_pattern_generator_unit.sv
rtl/dtpg_checker.sv
bench/display_test_pattern_generator_unit_checker.sv
bench/display_test_pattern_generator_unit_tb.sv
